FILE: hdl/pru_pkg.sv
// ----------------------------------------------------------------------------
// Pixel replicating upscaler package
// Shared field widths, register indexes, item kinds and stage control types.
// ----------------------------------------------------------------------------
package pru_pkg;

    localparam int PIXEL_W    = 24;
    localparam int ROW_WIDTH_W = 12;
    localparam int FACTOR_W   = 7;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'd1;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_PULL = 1'b1
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_OK = 3'd0,
        KIND_PIXEL   = 3'd1,
        KIND_PAD     = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_REFUSED = 3'd4
    } t_kind;

    // Control that travels with one item from the decision stage to the output.
    typedef struct packed {
        t_kind kind;
        logic  row_end;
        logic  src_done;
    } t_stage;

endpackage

FILE: hdl/pru_ram.sv
// ----------------------------------------------------------------------------
// Pixel replicating upscaler row RAM
// Simple dual port memory, one write port and one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pixel_replicating_upscaler.sv
// ----------------------------------------------------------------------------
// Pixel replicating upscaler
// Integer nearest neighbor upscaler for rows of 24-bit pixels, double buffered.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is either a push (tuser low) that
// stores one source pixel from tdata, or a pull (tuser high) that asks for the
// next output item. Every request produces exactly one response on the master
// stream: push accepted or refused, an output pixel, a zero pad byte, or
// nothing ready. tlast marks the last item of an output row; tuser bit 3 marks
// the last item of the final repetition of a source row.
// Two row banks in one RAM let a source row fill while the other replays.
// Each pixel is repeated scale_factor times, each output row is followed by
// zero pad bytes up to a four byte boundary, and each row is replayed
// scale_factor times before its bank is freed.
// Throughput: one request per clock while s_axis_tready is high. A response
// passes through the registered RAM read and then the output register. A
// request is taken while an earlier response waits, so a stalled receiver
// costs nothing until both internal stages are occupied; then s_axis_tready
// drops and all state holds until m_axis_tready returns.
// Reset clears all control state and sets both registers to one; the RAM is
// not cleared and needs no clearing pass. Configuration may only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 100
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pru_pkg::PIXEL_W-1:0]      s_axis_tdata,  // in_blue, in_green, in_red
    input  logic                             s_axis_tuser,  // action
    // Response stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pru_pkg::PIXEL_W-1:0]      m_axis_tdata,  // out_blue, out_green, out_red
    output logic                             m_axis_tlast,  // row_end
    output logic [pru_pkg::KIND_W:0]         m_axis_tuser   // kind, source_row_done
);

    import pru_pkg::*;

    // Address bits within a bank, bits that hold an effective width, and
    // bits that hold an effective factor.
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int RAM_DEPTH = 2 * (2 ** AW);

    // Configuration registers.
    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [FACTOR_W-1:0]    r_scale_factor;

    // Fill and replay state.
    logic [AW-1:0] r_fill_count, n_fill_count;
    logic          r_fill_bank, n_fill_bank;
    logic [1:0]    r_bank_full, n_bank_full;
    logic          r_replay_bank, n_replay_bank;
    logic [AW-1:0] r_replay_pixel, n_replay_pixel;
    logic [FW-1:0] r_pixel_copy, n_pixel_copy;
    logic [FW-1:0] r_row_copy, n_row_copy;
    logic [1:0]    r_pad_left, n_pad_left;
    logic          r_in_pad, n_in_pad;

    // Pipeline: decision stage (with RAM read in flight) and output register.
    logic                r_s1_valid;
    t_stage              r_s1, n_s1;
    logic                r_m_valid;
    t_stage              r_m;
    logic [PIXEL_W-1:0]  r_m_pixel;

    logic                accept;
    logic                s1_move;
    logic [WW-1:0]       eff_w;
    logic [FW-1:0]       eff_f;
    logic [WW-1:0]       fill_next;
    logic [WW-1:0]       replay_next;
    logic [FW-1:0]       copy_next;
    logic [FW-1:0]       row_next;
    logic [1:0]          w_mod;
    logic [1:0]          f_mod;
    logic [1:0]          pad_bytes;
    logic [1:0]          pad_dec;
    logic                finish_row;
    logic                ram_we;
    logic                ram_re;
    logic [PIXEL_W-1:0]  ram_rdata;

    // Out of range register values are clamped into the legal range.
    always_comb begin
        if (r_row_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_row_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_row_width);
        end
        if (r_scale_factor == '0) begin
            eff_f = FW'(1);
        end else if (32'(r_scale_factor) > 32'(MAX_FACTOR)) begin
            eff_f = FW'(MAX_FACTOR);
        end else begin
            eff_f = FW'(r_scale_factor);
        end
    end

    // Pad bytes after an output row: only the low two bits of width and
    // factor matter for the byte count modulo four.
    assign w_mod     = 2'(eff_w);
    assign f_mod     = 2'(eff_f);
    assign pad_bytes = 2'(2'd0 - 2'(w_mod * f_mod * 2'd3));

    assign fill_next   = WW'(r_fill_count) + WW'(1);
    assign replay_next = WW'(r_replay_pixel) + WW'(1);
    assign copy_next   = r_pixel_copy + FW'(1);
    assign row_next    = r_row_copy + FW'(1);
    assign pad_dec     = (r_pad_left == 2'd0) ? 2'd0 : r_pad_left - 2'd1;

    // Handshake: the decision stage can take a request whenever it is empty
    // or its current item moves on to the output register this cycle.
    assign s1_move       = r_s1_valid && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_fill_count   = r_fill_count;
        n_fill_bank    = r_fill_bank;
        n_bank_full    = r_bank_full;
        n_replay_bank  = r_replay_bank;
        n_replay_pixel = r_replay_pixel;
        n_pixel_copy   = r_pixel_copy;
        n_row_copy     = r_row_copy;
        n_pad_left     = r_pad_left;
        n_in_pad       = r_in_pad;
        n_s1.kind      = KIND_NONE;
        n_s1.row_end   = 1'b0;
        n_s1.src_done  = 1'b0;
        finish_row     = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (accept) begin
            if (s_axis_tuser == ACT_PUSH) begin
                if (r_bank_full[r_fill_bank]) begin
                    n_s1.kind = KIND_REFUSED;
                end else begin
                    n_s1.kind = KIND_PUSH_OK;
                    ram_we    = 1'b1;
                    if (fill_next >= eff_w) begin
                        n_fill_count              = '0;
                        n_bank_full[r_fill_bank] = 1'b1;
                        n_fill_bank               = ~r_fill_bank;
                    end else begin
                        n_fill_count = AW'(fill_next);
                    end
                end
            end else if (r_in_pad) begin
                n_s1.kind  = KIND_PAD;
                n_pad_left = pad_dec;
                if (pad_dec == 2'd0) begin
                    n_in_pad   = 1'b0;
                    finish_row = 1'b1;
                end
            end else if (!r_bank_full[r_replay_bank]) begin
                n_s1.kind = KIND_NONE;
            end else begin
                n_s1.kind = KIND_PIXEL;
                ram_re    = 1'b1;
                if (copy_next >= eff_f) begin
                    n_pixel_copy = '0;
                    if (replay_next >= eff_w) begin
                        n_replay_pixel = '0;
                        if (pad_bytes != 2'd0) begin
                            n_in_pad   = 1'b1;
                            n_pad_left = pad_bytes;
                        end else begin
                            finish_row = 1'b1;
                        end
                    end else begin
                        n_replay_pixel = AW'(replay_next);
                    end
                end else begin
                    n_pixel_copy = copy_next;
                end
            end

            // Close an output row; the last repetition frees the bank.
            if (finish_row) begin
                n_s1.row_end = 1'b1;
                if (row_next >= eff_f) begin
                    n_row_copy                  = '0;
                    n_s1.src_done               = 1'b1;
                    n_bank_full[r_replay_bank] = 1'b0;
                    n_replay_bank               = ~r_replay_bank;
                end else begin
                    n_row_copy = row_next;
                end
            end
        end
    end

    pru_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_fill_bank, r_fill_count}),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr ({r_replay_bank, r_replay_pixel}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= ROW_WIDTH_W'(1);
            r_scale_factor <= FACTOR_W'(1);
            r_fill_count   <= '0;
            r_fill_bank    <= 1'b0;
            r_bank_full    <= 2'b00;
            r_replay_bank  <= 1'b0;
            r_replay_pixel <= '0;
            r_pixel_copy   <= '0;
            r_row_copy     <= '0;
            r_pad_left     <= 2'd0;
            r_in_pad       <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROW_WIDTH) begin
                    r_row_width <= i_cfg_wdata[ROW_WIDTH_W-1:0];
                end else if (i_cfg_index == REG_SCALE_FACTOR) begin
                    r_scale_factor <= i_cfg_wdata[FACTOR_W-1:0];
                end
            end
            r_fill_count   <= n_fill_count;
            r_fill_bank    <= n_fill_bank;
            r_bank_full    <= n_bank_full;
            r_replay_bank  <= n_replay_bank;
            r_replay_pixel <= n_replay_pixel;
            r_pixel_copy   <= n_pixel_copy;
            r_row_copy     <= n_row_copy;
            r_pad_left     <= n_pad_left;
            r_in_pad       <= n_in_pad;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_m       <= r_s1;
            r_m_pixel <= (r_s1.kind == KIND_PIXEL) ? ram_rdata : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_pixel;
    assign m_axis_tlast  = r_m.row_end;
    assign m_axis_tuser  = {r_m.src_done, r_m.kind};

endmodule
